// ===== design/multilevel_ready_queue_dispatch_top_defines.svh =====
// Assertion macros used by the checker of the ready-queue dispatcher.
`ifndef MULTILEVEL_READY_QUEUE_DISPATCH_TOP_DEFINES_SVH
`define MULTILEVEL_READY_QUEUE_DISPATCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MRQD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define MRQD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mrqd_pkg.sv =====
// Shared types and constants of the multilevel ready-queue dispatcher.
package mrqd_pkg;

    localparam int MAX_PROCESSES_DEF = 64;
    localparam int LEVELS_DEF        = 6;

    localparam int CMD_W    = 2;
    localparam int PID_W    = 6;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_DISPATCH = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_HALT      = 2'd2,
        ST_QUEUED    = 2'd3
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PID_W-1:0]  pid;
        logic [PRIO_W-1:0] priority_req;
        logic              rotate;
        logic [PID_W-1:0]  current_pid;
        logic [PRIO_W-1:0] current_priority;
        logic              current_running;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [PID_W-1:0] selected_pid;
        logic             switch_needed;
    } t_rsp;

    // top -> core handshake control
    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    // core -> top status
    typedef struct packed {
        logic idle;
        logic done;
    } t_core_sts;

endpackage

// ===== design/mrqd_req_if.sv =====
// Command channel: valid/ready handshake with the command fields.
interface mrqd_req_if;
    import mrqd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] priority_req;
    logic              rotate;
    logic [PID_W-1:0]  current_pid;
    logic [PRIO_W-1:0] current_priority;
    logic              current_running;

    modport source (
        output valid, command, pid, priority_req, rotate,
               current_pid, current_priority, current_running,
        input  ready
    );

    modport sink (
        input  valid, command, pid, priority_req, rotate,
               current_pid, current_priority, current_running,
        output ready
    );
endinterface

// ===== design/mrqd_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
interface mrqd_rsp_if;
    import mrqd_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PID_W-1:0]    selected_pid;
    logic                switch_needed;

    modport source (
        output valid, status, selected_pid, switch_needed,
        input  ready
    );

    modport sink (
        input  valid, status, selected_pid, switch_needed,
        output ready
    );
endinterface

// ===== design/mrqd_core.sv =====
// Ready-queue sequencer: level head/tail registers, link and level memories.
module mrqd_core #(
    parameter int MAX_PROCESSES = mrqd_pkg::MAX_PROCESSES_DEF,
    parameter int LEVELS        = mrqd_pkg::LEVELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  mrqd_pkg::t_core_ctl   i_ctl,
    input  mrqd_pkg::t_req        i_req,
    output mrqd_pkg::t_core_sts   o_sts,
    output mrqd_pkg::t_rsp        o_rsp
);
    import mrqd_pkg::*;

    localparam int IW = $clog2(MAX_PROCESSES);
    localparam int LW = $clog2(MAX_PROCESSES + 1);
    localparam int VW = $clog2(LEVELS);
    localparam logic [LW-1:0] NIL = LW'(MAX_PROCESSES);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DECODE    = 12'b0000_0000_0010,
        S_ENQ       = 12'b0000_0000_0100,
        S_ENQ_LINK  = 12'b0000_0000_1000,
        S_POP       = 12'b0000_0001_0000,
        S_POP_WR    = 12'b0000_0010_0000,
        S_LVL_RD    = 12'b0000_0100_0000,
        S_WALK_INIT = 12'b0000_1000_0000,
        S_WALK      = 12'b0001_0000_0000,
        S_STEP      = 12'b0010_0000_0000,
        S_UNLINK    = 12'b0100_0000_0000,
        S_DONE      = 12'b1000_0000_0000
    } t_state;

    // map a 1-based priority onto a level index, saturating at both ends
    function automatic logic [VW-1:0] clamp_level(input logic [PRIO_W-1:0] prio);
        logic [VW-1:0] lvl;
        if (prio == '0) begin
            lvl = '0;
        end else if (32'(prio) > LEVELS) begin
            lvl = VW'(LEVELS - 1);
        end else begin
            lvl = VW'(32'(prio) - 32'd1);
        end
        return lvl;
    endfunction

    function automatic logic pid_in_range(input logic [PID_W-1:0] p);
        return 32'(p) < MAX_PROCESSES;
    endfunction

    // control state
    t_state                r_state, n_state;
    logic [LW-1:0]         r_head [LEVELS];
    logic [LW-1:0]         n_head [LEVELS];
    logic [LW-1:0]         r_tail [LEVELS];
    logic [LW-1:0]         n_tail [LEVELS];
    logic [MAX_PROCESSES-1:0] r_queued, n_queued;

    // per-transaction working registers
    t_req                  r_req, n_req;
    logic [VW-1:0]         r_lvl, n_lvl;
    logic [VW-1:0]         r_top, n_top;
    logic [IW-1:0]         r_tgt, n_tgt;
    logic [LW-1:0]         r_cur, n_cur;
    logic [LW-1:0]         r_prev, n_prev;
    logic [LW-1:0]         r_tail_old, n_tail_old;
    logic                  r_pop_after, n_pop_after;
    t_rsp                  r_rsp, n_rsp;

    // memories
    logic [LW-1:0]         r_link_mem [MAX_PROCESSES];
    logic [LW-1:0]         r_link_rd;
    logic [VW-1:0]         r_lvl_mem [MAX_PROCESSES];
    logic [VW-1:0]         r_lvl_rd;

    logic                  link_we;
    logic [IW-1:0]         link_waddr;
    logic [LW-1:0]         link_wdata;
    logic [IW-1:0]         link_raddr;
    logic                  lvl_we;

    logic                  top_found;
    logic [VW-1:0]         top_lvl;
    logic [VW-1:0]         cur_lvl;
    logic [IW-1:0]         cur_idx;

    // most urgent non-empty level
    always_comb begin
        top_found = 1'b0;
        top_lvl   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_head[l] != NIL) begin
                top_found = 1'b1;
                top_lvl   = VW'(l);
            end
        end
    end

    assign cur_lvl = clamp_level(r_req.current_priority);
    assign cur_idx = IW'(r_req.current_pid);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_queued    = r_queued;
        n_req       = r_req;
        n_lvl       = r_lvl;
        n_top       = r_top;
        n_tgt       = r_tgt;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_tail_old  = r_tail_old;
        n_pop_after = r_pop_after;
        n_rsp       = r_rsp;
        link_we     = 1'b0;
        link_waddr  = r_tgt;
        link_wdata  = NIL;
        link_raddr  = r_tgt;
        lvl_we      = 1'b0;
        o_sts.idle  = 1'b0;
        o_sts.done  = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_sts.idle = 1'b1;
                if (i_ctl.start) begin
                    n_req   = i_req;
                    n_tgt   = IW'(i_req.pid);
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_rsp       = '0;
                n_pop_after = 1'b0;
                n_state     = S_DONE;
                case (t_cmd'(r_req.command))
                    CMD_ADD: begin
                        if (pid_in_range(r_req.pid)) begin
                            if (r_queued[r_tgt]) begin
                                n_rsp.status = ST_QUEUED;
                            end else begin
                                n_lvl   = clamp_level(r_req.priority_req);
                                n_state = S_ENQ;
                            end
                        end
                    end
                    CMD_REMOVE: begin
                        if (!pid_in_range(r_req.pid)) begin
                            n_rsp.status = ST_NOT_FOUND;
                        end else if (!r_queued[r_tgt]) begin
                            n_rsp.status = ST_NOT_FOUND;
                        end else begin
                            n_state = S_LVL_RD;
                        end
                    end
                    CMD_DISPATCH: begin
                        if (!r_req.current_running) begin
                            if (!top_found) begin
                                n_rsp.status = ST_HALT;
                            end else begin
                                n_lvl   = top_lvl;
                                n_state = S_POP;
                            end
                        end else if (!top_found) begin
                            n_rsp.selected_pid = r_req.current_pid;
                        end else if ((top_lvl < cur_lvl)
                                     || (r_req.rotate && (top_lvl == cur_lvl))) begin
                            n_top = top_lvl;
                            if (pid_in_range(r_req.current_pid) && !r_queued[cur_idx]) begin
                                // requeue the running process before the pop
                                n_tgt       = cur_idx;
                                n_lvl       = cur_lvl;
                                n_pop_after = 1'b1;
                                n_state     = S_ENQ;
                            end else begin
                                n_lvl   = top_lvl;
                                n_state = S_POP;
                            end
                        end else begin
                            n_rsp.selected_pid = r_req.current_pid;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            // append r_tgt at the tail of level r_lvl
            S_ENQ: begin
                link_we          = 1'b1;
                link_waddr       = r_tgt;
                link_wdata       = NIL;
                lvl_we           = 1'b1;
                n_queued[r_tgt]  = 1'b1;
                n_tail[r_lvl]    = LW'(r_tgt);
                if (r_head[r_lvl] == NIL) begin
                    n_head[r_lvl] = LW'(r_tgt);
                    if (r_pop_after) begin
                        n_lvl   = r_top;
                        n_state = S_POP;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_tail_old = r_tail[r_lvl];
                    n_state    = S_ENQ_LINK;
                end
            end

            S_ENQ_LINK: begin
                link_we    = 1'b1;
                link_waddr = r_tail_old[IW-1:0];
                link_wdata = LW'(r_tgt);
                if (r_pop_after) begin
                    n_lvl   = r_top;
                    n_state = S_POP;
                end else begin
                    n_state = S_DONE;
                end
            end

            // pop the head of level r_lvl
            S_POP: begin
                link_raddr = r_head[r_lvl][IW-1:0];
                n_cur      = r_head[r_lvl];
                n_state    = S_POP_WR;
            end

            S_POP_WR: begin
                n_head[r_lvl] = r_link_rd;
                if (r_link_rd == NIL) begin
                    n_tail[r_lvl] = NIL;
                end
                n_queued[r_cur[IW-1:0]] = 1'b0;
                n_rsp.selected_pid      = PID_W'(r_cur);
                n_rsp.switch_needed     = !r_req.current_running
                                          || (PID_W'(r_cur) != r_req.current_pid);
                n_state                 = S_DONE;
            end

            // remove: find the level, then walk its list
            S_LVL_RD: begin
                n_lvl   = r_lvl_rd;
                n_state = S_WALK_INIT;
            end

            S_WALK_INIT: begin
                n_cur   = r_head[r_lvl];
                n_prev  = NIL;
                n_state = S_WALK;
            end

            S_WALK: begin
                if (r_cur == NIL) begin
                    n_rsp.status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else if (r_cur == LW'(r_tgt)) begin
                    link_raddr = r_tgt;
                    n_state    = S_UNLINK;
                end else begin
                    link_raddr = r_cur[IW-1:0];
                    n_prev     = r_cur;
                    n_state    = S_STEP;
                end
            end

            S_STEP: begin
                n_cur   = r_link_rd;
                n_state = S_WALK;
            end

            S_UNLINK: begin
                if (r_prev == NIL) begin
                    n_head[r_lvl] = r_link_rd;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[IW-1:0];
                    link_wdata = r_link_rd;
                end
                if (r_tail[r_lvl] == LW'(r_tgt)) begin
                    n_tail[r_lvl] = r_prev;
                end
                n_queued[r_tgt] = 1'b0;
                n_state         = S_DONE;
            end

            S_DONE: begin
                if (i_ctl.take) begin
                    o_sts.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp = r_rsp;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '{default: NIL};
            r_tail   <= '{default: NIL};
            r_queued <= '0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_queued <= n_queued;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_lvl       <= n_lvl;
        r_top       <= n_top;
        r_tgt       <= n_tgt;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_tail_old  <= n_tail_old;
        r_pop_after <= n_pop_after;
        r_rsp       <= n_rsp;
    end

    // link memory: next pid in the same level
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            r_link_mem[link_waddr] <= link_wdata;
        end
        r_link_rd <= r_link_mem[link_raddr];
    end

    // level memory: level a queued pid sits in
    always_ff @(posedge i_clk) begin
        if (lvl_we) begin
            r_lvl_mem[r_tgt] <= r_lvl;
        end
        r_lvl_rd <= r_lvl_mem[r_tgt];
    end

endmodule

// ===== design/multilevel_ready_queue_dispatch_top.sv =====
// An add decodes the command, enqueues the pid and, into a non-empty level, links it behind
// the old tail; a dispatch may requeue the running pid and then pop the most urgent head; a
// remove reads the pid's level, then walks that level's list from its head up to the pid.
// One transaction at a time: the next is taken the cycle after a result is handed to the
// output register. Reset (synchronous, active low) empties all levels and clears the queued
// flags at once; no clearing pass is needed, the link and level memories are never used unwritten.
module multilevel_ready_queue_dispatch_top #(
    parameter int MAX_PROCESSES = mrqd_pkg::MAX_PROCESSES_DEF,
    parameter int LEVELS        = mrqd_pkg::LEVELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mrqd_req_if.sink     i_req,
    mrqd_rsp_if.source   o_rsp
);
    import mrqd_pkg::*;

    t_req      req;
    t_rsp      core_rsp;
    t_rsp      r_rsp;
    logic      r_out_valid;
    t_core_ctl core_ctl;
    t_core_sts core_sts;

    // gather the command fields
    always_comb begin
        req.command          = i_req.command;
        req.pid              = i_req.pid;
        req.priority_req     = i_req.priority_req;
        req.rotate           = i_req.rotate;
        req.current_pid      = i_req.current_pid;
        req.current_priority = i_req.current_priority;
        req.current_running  = i_req.current_running;
    end

    assign i_req.ready   = core_sts.idle;
    assign core_ctl.start = i_req.valid && core_sts.idle;
    assign core_ctl.take  = !r_out_valid || o_rsp.ready;

    mrqd_core #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .LEVELS        (LEVELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_req   (req),
        .o_sts   (core_sts),
        .o_rsp   (core_rsp)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_sts.done) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_sts.done) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_rsp.status;
    assign o_rsp.selected_pid  = r_rsp.selected_pid;
    assign o_rsp.switch_needed = r_rsp.switch_needed;

endmodule

// ===== design/mrqd_checker.sv =====
// Port-level checks of the ready-queue dispatcher, bound to the top level.
`include "multilevel_ready_queue_dispatch_top_defines.svh"

module mrqd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mrqd_pkg::STATUS_W-1:0] status,
    input logic [mrqd_pkg::PID_W-1:0]    selected_pid,
    input logic                          switch_needed
);
    import mrqd_pkg::*;

    // one transaction in flight: no new command right after one is taken
    `MRQD_ASSERT_NEXT(a_single_txn, in_valid && in_ready, !in_ready, "command taken while busy")

    // error and halt results carry no selection
    `MRQD_ASSERT_SAME(a_err_clean, out_valid && (status != ST_OK), (selected_pid == '0) && !switch_needed, "error result with selection")

    // a new result only comes out of a busy sequencer
    `MRQD_ASSERT_SAME(a_rise_busy, $rose(out_valid) && $past(i_rst_n), !$past(in_ready), "result without work")

    // stalled result holds
    `MRQD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(selected_pid) && $stable(switch_needed), "stalled result changed")

endmodule

bind multilevel_ready_queue_dispatch_top mrqd_checker u_mrqd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .in_valid      (i_req.valid),
    .in_ready      (i_req.ready),
    .out_valid     (o_rsp.valid),
    .out_ready     (o_rsp.ready),
    .status        (o_rsp.status),
    .selected_pid  (o_rsp.selected_pid),
    .switch_needed (o_rsp.switch_needed)
);
